// ----- rtl/c2e_pkg.sv -----
// Shared types, constants and helper functions for the calendar to epoch seconds converter.
// Has no dependencies. Every rtl module refers to it by scoped names.
package c2e_pkg;

	localparam logic [11:0] EPOCH_YEAR_RESET = 12'd1970;
	localparam logic [16:0] DAYS_PER_YEAR    = 17'd365;
	localparam logic [16:0] SECS_PER_HOUR    = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN     = 17'd60;
	localparam logic [33:0] SECS_PER_DAY     = 34'd86400;
	localparam logic [11:0] RECIP_25         = 12'd2622;
	localparam int          RECIP_SHIFT      = 16;
	localparam logic [3:0]  MONTH_MAR_IDX    = 4'd2;
	localparam logic [3:0]  MONTH_DEC_IDX    = 4'd11;

	typedef struct packed {
		logic [12:0] cur;
		logic [11:0] epoch;
		logic [16:0] yd;
		logic [3:0]  midx;
		logic [4:0]  day0;
		logic [16:0] tod;
	} prep_t;

	typedef struct packed {
		logic [16:0] yd;
		logic [6:0]  leaps;
		logic        leap;
		logic [3:0]  midx;
		logic [4:0]  day0;
		logic [16:0] tod;
	} leap_t;

	typedef struct packed {
		logic [16:0] days;
		logic [16:0] tod;
	} days_t;

	// floor(x / 25), exact for x below 4681
	function automatic logic [6:0] div25(input logic [10:0] x);
		logic [22:0] p;
		p = {12'b0, x} * {11'b0, RECIP_25};
		return p[RECIP_SHIFT +: 7];
	endfunction

	// leap years in 0 .. n-1
	function automatic logic [10:0] leaps_below(input logic [12:0] n);
		logic [12:0] a3;
		logic [12:0] a99;
		logic [12:0] a399;
		logic [6:0]  q100;
		logic [6:0]  q400;
		a3   = n + 13'd3;
		a99  = n + 13'd99;
		a399 = n + 13'd399;
		q100 = div25(a99[12:2]);
		q400 = div25({2'b0, a399[12:4]});
		return a3[12:2] - {4'b0, q100} + {4'b0, q400};
	endfunction

	function automatic logic is_leap(input logic [12:0] y);
		logic [10:0] y4;
		logic [10:0] y16;
		logic [10:0] m4;
		logic [10:0] m16;
		logic        by100;
		logic        by400;
		y4    = y[12:2];
		y16   = {2'b0, y[12:4]};
		m4    = {4'b0, div25(y4)} * 11'd25;
		m16   = {4'b0, div25(y16)} * 11'd25;
		by100 = (y[1:0] == 2'd0) && (m4 == y4);
		by400 = (y[3:0] == 4'd0) && (m16 == y16);
		return ((y[1:0] == 2'd0) && !by100) || by400;
	endfunction

	function automatic logic [8:0] days_before_month(input logic [3:0] idx);
		logic [8:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/c2e_prep.sv -----
// First pipeline stage: current year, whole-year days, month and day clamping, time of day.
// Depends on c2e_pkg.
module c2e_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [11:0]          epoch_year,
	input  logic [7:0]           years_since_epoch,
	input  logic [3:0]           month_number,
	input  logic [4:0]           day_of_month,
	input  logic [4:0]           hour_of_day,
	input  logic [5:0]           minute_of_hour,
	input  logic [5:0]           second_of_minute,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2e_pkg::prep_t       out_data
);

	logic           valid_s1;
	c2e_pkg::prep_t data_s1;
	c2e_pkg::prep_t nxt;

	always_comb begin
		nxt.cur   = {1'b0, epoch_year} + {5'b0, years_since_epoch};
		nxt.epoch = epoch_year;
		nxt.yd    = {9'b0, years_since_epoch} * c2e_pkg::DAYS_PER_YEAR;
		if (month_number == 4'd0) begin
			nxt.midx = 4'd0;
		end else if (month_number > 4'd12) begin
			nxt.midx = c2e_pkg::MONTH_DEC_IDX;
		end else begin
			nxt.midx = month_number - 4'd1;
		end
		nxt.day0 = (day_of_month == 5'd0) ? 5'd0 : day_of_month - 5'd1;
		nxt.tod  = {12'b0, hour_of_day} * c2e_pkg::SECS_PER_HOUR
			+ {11'b0, minute_of_hour} * c2e_pkg::SECS_PER_MIN
			+ {11'b0, second_of_minute};
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/c2e_leap.sv -----
// Second pipeline stage: leap-year count between epoch and current year, leap test of current year.
// Depends on c2e_pkg.
module c2e_leap (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2e_pkg::prep_t       in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2e_pkg::leap_t       out_data
);

	logic           valid_s2;
	c2e_pkg::leap_t data_s2;
	c2e_pkg::leap_t nxt;
	logic [10:0]    diff;

	always_comb begin
		diff      = c2e_pkg::leaps_below(in_data.cur)
			- c2e_pkg::leaps_below({1'b0, in_data.epoch});
		nxt.yd    = in_data.yd;
		nxt.leaps = diff[6:0];
		nxt.leap  = c2e_pkg::is_leap(in_data.cur);
		nxt.midx  = in_data.midx;
		nxt.day0  = in_data.day0;
		nxt.tod   = in_data.tod;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/c2e_days.sv -----
// Third pipeline stage: total day count from years, leap days, months and day of month.
// Depends on c2e_pkg.
module c2e_days (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2e_pkg::leap_t       in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2e_pkg::days_t       out_data
);

	logic           valid_s3;
	c2e_pkg::days_t data_s3;
	c2e_pkg::days_t nxt;
	logic           feb29;

	always_comb begin
		feb29    = in_data.leap && (in_data.midx >= c2e_pkg::MONTH_MAR_IDX);
		nxt.days = in_data.yd
			+ {10'b0, in_data.leaps}
			+ {8'b0, c2e_pkg::days_before_month(in_data.midx)}
			+ {16'b0, feb29}
			+ {12'b0, in_data.day0};
		nxt.tod  = in_data.tod;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ----- rtl/c2e_secs.sv -----
// Fourth pipeline stage and output register: days to seconds, plus time of day, wrap flag.
// Depends on c2e_pkg.
module c2e_secs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2e_pkg::days_t       in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          epoch_seconds,
	output logic                 wrapped
);

	logic        valid_s4;
	logic [31:0] secs_s4;
	logic        wrap_s4;
	logic [33:0] total;

	assign total = {17'b0, in_data.days} * c2e_pkg::SECS_PER_DAY + {17'b0, in_data.tod};

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			secs_s4 <= total[31:0];
			wrap_s4 <= |total[33:32];
		end
	end

	assign out_valid     = valid_s4;
	assign epoch_seconds = secs_s4;
	assign wrapped       = wrap_s4;

endmodule

// ----- rtl/calendar_to_epoch_seconds.sv -----
// Top level of the calendar to epoch seconds converter: epoch register, four-stage pipeline.
// Depends on c2e_pkg, c2e_prep, c2e_leap, c2e_days and c2e_secs.
//
// Usage:
// - Input items arrive on s_axis_*: years since epoch, month, day, hour, minute and second.
// - Each item yields exactly one result item on m_axis_*: the 32-bit second count since
//   January 1, 00:00:00 of the epoch year, and in tuser a flag set when the count wrapped.
// - The epoch year is written through cfg_valid/cfg_data; cfg_ready is always high. Write it
//   only while no items are in flight.
// - An accepted item passes through four register stages to the result. One item is
//   accepted per cycle while the receiver takes results. The stages are year prep, leap
//   counting (reciprocal multiplies by 1/25), day summing, and the days-to-seconds multiply.
// - Each stage has its own valid bit and takes a new item whenever it is empty or its
//   successor takes its item, so bubbles close up and a stalled receiver holds the result
//   in the output register while up to three more items are taken in.
// - Reset clears all valid bits and sets the epoch year to 1970.
module calendar_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,      // epoch_year
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// years_since_epoch[7:0], month_number[11:8], day_of_month[16:12],
	// hour_of_day[21:17], minute_of_hour[27:22], second_of_minute[33:28], zero[39:34]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // epoch_seconds[31:0]
	output logic [0:0]  m_axis_tuser   // wrapped[0]
);

	logic [11:0]    epoch_year_q;
	logic           valid_s1;
	logic           valid_s2;
	logic           valid_s3;
	logic           ready_s2;
	logic           ready_s3;
	logic           ready_s4;
	c2e_pkg::prep_t data_s1;
	c2e_pkg::leap_t data_s2;
	c2e_pkg::days_t data_s3;
	logic           wrapped;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_year_q <= c2e_pkg::EPOCH_YEAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			epoch_year_q <= cfg_data;
		end
	end

	c2e_prep u_prep (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.epoch_year        (epoch_year_q),
		.years_since_epoch (s_axis_tdata[7:0]),
		.month_number      (s_axis_tdata[11:8]),
		.day_of_month      (s_axis_tdata[16:12]),
		.hour_of_day       (s_axis_tdata[21:17]),
		.minute_of_hour    (s_axis_tdata[27:22]),
		.second_of_minute  (s_axis_tdata[33:28]),
		.out_valid         (valid_s1),
		.out_ready         (ready_s2),
		.out_data          (data_s1)
	);

	c2e_leap u_leap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s2),
		.in_data   (data_s1),
		.out_valid (valid_s2),
		.out_ready (ready_s3),
		.out_data  (data_s2)
	);

	c2e_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (ready_s3),
		.in_data   (data_s2),
		.out_valid (valid_s3),
		.out_ready (ready_s4),
		.out_data  (data_s3)
	);

	c2e_secs u_secs (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s3),
		.in_ready      (ready_s4),
		.in_data       (data_s3),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.epoch_seconds (m_axis_tdata),
		.wrapped       (wrapped)
	);

	assign m_axis_tuser = wrapped;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register empty");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted item not held in first stage");

	a_result_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s3))
		else $error("result appeared without an item in third stage");

endmodule
